/* rtl/core/assert_macros.svh */
// Assertion macros used by the top level RTL file of the parameter set parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define SPS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `SPS_ASSERT(label, clk, rst, !(cond), msg)

`endif

/* rtl/core/sps_pkg.sv */
// Types, syntax element numbers and helper functions of the parameter set parser.
package sps_pkg;

   localparam int MAX_CYCLE_OFFSETS = 16;
   localparam int MAX_CODE_ZEROS    = 32;

   localparam logic [5:0] F_PROFILE    = 6'd0;
   localparam logic [5:0] F_LEVEL      = 6'd2;
   localparam logic [5:0] F_SPS_ID     = 6'd3;
   localparam logic [5:0] F_CHROMA     = 6'd4;
   localparam logic [5:0] F_SEP_PLANE  = 6'd5;
   localparam logic [5:0] F_BITDEPTH_L = 6'd6;
   localparam logic [5:0] F_QPPRIME    = 6'd8;
   localparam logic [5:0] F_SCALING    = 6'd9;
   localparam logic [5:0] F_CAT        = 6'd10;
   localparam logic [5:0] F_LOG2FN     = 6'd11;
   localparam logic [5:0] F_POC_TYPE   = 6'd12;
   localparam logic [5:0] F_POC_LSB    = 6'd13;
   localparam logic [5:0] F_DELTA_ZERO = 6'd14;
   localparam logic [5:0] F_OFF_NONREF = 6'd15;
   localparam logic [5:0] F_OFF_TB     = 6'd16;
   localparam logic [5:0] F_NUM_CYCLE  = 6'd17;
   localparam logic [5:0] F_OFF_REF    = 6'd18;
   localparam logic [5:0] F_NUM_REF    = 6'd19;
   localparam logic [5:0] F_GAPS       = 6'd20;
   localparam logic [5:0] F_FRAME_MBS  = 6'd23;
   localparam logic [5:0] F_MBAFF      = 6'd24;
   localparam logic [5:0] F_DIRECT     = 6'd25;
   localparam logic [5:0] F_CROP       = 6'd26;
   localparam logic [5:0] F_CROP_LEFT  = 6'd27;
   localparam logic [5:0] F_VUI        = 6'd31;
   localparam logic [5:0] F_ASPECT     = 6'd32;
   localparam logic [5:0] F_VCL_HRD    = 6'd38;
   localparam logic [5:0] F_BS_RESTR   = 6'd40;
   localparam logic [5:0] F_MV_OVER    = 6'd41;
   localparam logic [5:0] F_MAX_DEC    = 6'd47;
   localparam logic [5:0] END_ID       = 6'd48;

   localparam logic [5:0] STEP_STOP = 6'd48;
   localparam logic [5:0] STEP_PAD  = 6'd49;
   localparam logic [5:0] STEP_DROP = 6'd50;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
   localparam logic [2:0] ST_TRAILING    = 3'd2;
   localparam logic [2:0] ST_TRUNCATED   = 3'd3;
   localparam logic [2:0] ST_OVERFLOW    = 3'd4;

   localparam logic [32:0] LOG2FN_LIMIT = 33'd4294967290;

   localparam logic [7:0] PROF_100 = 8'd100;
   localparam logic [7:0] PROF_110 = 8'd110;
   localparam logic [7:0] PROF_122 = 8'd122;
   localparam logic [7:0] PROF_244 = 8'd244;
   localparam logic [7:0] PROF_44  = 8'd44;
   localparam logic [7:0] PROF_83  = 8'd83;
   localparam logic [7:0] PROF_86  = 8'd86;
   localparam logic [7:0] PROF_118 = 8'd118;
   localparam logic [7:0] PROF_128 = 8'd128;
   localparam logic [7:0] PROF_138 = 8'd138;
   localparam logic [7:0] PROF_139 = 8'd139;
   localparam logic [7:0] PROF_134 = 8'd134;
   localparam logic [7:0] PROF_135 = 8'd135;

   typedef enum logic [1:0] {K_FIX8, K_BIT, K_UE, K_SE} kind_type;

   typedef struct packed {
      logic [7:0] rbsp_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   function automatic kind_type kind_of(input logic [5:0] s);
      kind_type k;
      if (s <= F_LEVEL) k = K_FIX8;
      else if (s == F_OFF_NONREF || s == F_OFF_TB || s == F_OFF_REF) k = K_SE;
      else if (s == F_SEP_PLANE || s == F_QPPRIME || s == F_SCALING || s == F_DELTA_ZERO ||
               s == F_GAPS || (s >= F_FRAME_MBS && s <= F_CROP) ||
               (s >= F_VUI && s <= F_MV_OVER)) k = K_BIT;
      else k = K_UE;
      return k;
   endfunction

   function automatic logic is_high(input logic [7:0] p);
      return p == PROF_100 || p == PROF_110 || p == PROF_122 || p == PROF_244 ||
             p == PROF_44 || p == PROF_83 || p == PROF_86 || p == PROF_118 ||
             p == PROF_128 || p == PROF_138 || p == PROF_139 || p == PROF_134 ||
             p == PROF_135;
   endfunction

endpackage

/* rtl/core/sps_front.sv */
// Input side of the parser: accepts bytes and holds them in a two-entry queue.
module sps_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sps_pkg::item_type req_item,
   output sps_pkg::head_type head,
   input  logic              pop
);
   import sps_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       take;

   assign req_ready = count_ff != 2'd2;
   assign push = req_valid && req_ready;
   assign take = pop && count_ff != 2'd0;
   assign head.valid = count_ff != 2'd0;
   assign head.item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

/* rtl/core/sps_back.sv */
// Bit-serial syntax walker of the parser with its output record register.
module sps_back (
   input  logic                clock,
   input  logic                reset,
   input  sps_pkg::head_type   head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic         [5:0]  rsp_field_id,
   output logic         [7:0]  rsp_element_index,
   output logic signed  [32:0] rsp_field_value,
   output logic         [2:0]  rsp_parse_status,
   output logic                rsp_set_done
);
   import sps_pkg::*;

   logic [5:0]  step_ff, step_in;
   logic [5:0]  bits_ff, bits_in;
   logic [5:0]  lz_ff, lz_in;
   logic [32:0] acc_ff, acc_in;
   logic [7:0]  prof_ff, prof_in;
   logic [1:0]  chroma_ff, chroma_in;
   logic        sep_ff, sep_in;
   logic [7:0]  lcount_ff, lcount_in;
   logic [7:0]  llimit_ff, llimit_in;
   logic [2:0]  err_ff, err_in;
   logic        failp_ff, failp_in;
   logic [2:0]  bitpos_ff, bitpos_in;
   logic        tail_ff, tail_in;

   logic        out_valid_ff, out_valid_in;
   logic [5:0]  out_id_ff, out_id_in;
   logic [7:0]  out_idx_ff, out_idx_in;
   logic [32:0] out_val_ff, out_val_in;
   logic [2:0]  out_st_ff, out_st_in;
   logic        out_done_ff, out_done_in;

   logic        adv;
   logic        emit;
   logic        bitv;
   logic        do_cmp;
   logic        fail_now;
   logic [2:0]  fail_code;
   logic [32:0] cv, cw;
   logic [32:0] acc_sh;
   logic [32:0] code;
   logic [7:0]  lc_next;
   kind_type    kind;

   assign adv = !out_valid_ff || rsp_ready;

   always_comb begin
      step_in = step_ff;
      bits_in = bits_ff;
      lz_in = lz_ff;
      acc_in = acc_ff;
      prof_in = prof_ff;
      chroma_in = chroma_ff;
      sep_in = sep_ff;
      lcount_in = lcount_ff;
      llimit_in = llimit_ff;
      err_in = err_ff;
      failp_in = failp_ff;
      bitpos_in = bitpos_ff;
      tail_in = tail_ff;
      out_valid_in = adv ? 1'b0 : out_valid_ff;
      out_id_in = out_id_ff;
      out_idx_in = out_idx_ff;
      out_val_in = out_val_ff;
      out_st_in = out_st_ff;
      out_done_in = out_done_ff;
      emit = 1'b0;
      pop = 1'b0;
      do_cmp = 1'b0;
      fail_now = 1'b0;
      fail_code = ST_OK;
      cv = '0;
      cw = '0;
      acc_sh = {acc_ff[31:0], 1'b0};
      code = '0;
      lc_next = lcount_ff + 8'd1;
      bitv = head.item.rbsp_byte[bitpos_ff];
      kind = kind_of(step_ff);

      if (adv) begin
         if (step_ff == F_CAT) begin
            emit = 1'b1;
            out_id_in = F_CAT;
            out_idx_in = '0;
            out_val_in = sep_ff ? 33'd0 : {31'd0, chroma_ff};
            out_st_in = ST_OK;
            out_done_in = 1'b0;
            step_in = F_LOG2FN;
         end else if (failp_ff) begin
            fail_now = 1'b1;
            fail_code = err_ff;
            failp_in = 1'b0;
         end else if (head.valid) begin
            if (tail_ff) begin
               if (head.item.last_byte) begin
                  if (step_ff == STEP_PAD) begin
                     fail_now = 1'b1;
                     fail_code = ST_OK;
                  end else if (step_ff == STEP_STOP) begin
                     fail_now = 1'b1;
                     fail_code = ST_TRAILING;
                  end else if (step_ff < STEP_STOP) begin
                     fail_now = 1'b1;
                     fail_code = ST_TRUNCATED;
                  end
               end
               pop = 1'b1;
               tail_in = 1'b0;
               bitpos_in = 3'd7;
            end else begin
               acc_sh = {acc_ff[31:0], bitv};
               if (step_ff == STEP_DROP) begin
                  step_in = STEP_DROP;
               end else if (step_ff == STEP_STOP) begin
                  if (bitv) begin
                     step_in = STEP_PAD;
                  end else begin
                     fail_now = 1'b1;
                     fail_code = ST_TRAILING;
                  end
               end else if (step_ff == STEP_PAD) begin
                  if (bitv) begin
                     fail_now = 1'b1;
                     fail_code = ST_TRAILING;
                  end
               end else begin
                  case (kind)
                     K_BIT: begin
                        do_cmp = 1'b1;
                        cv = {32'd0, bitv};
                        cw = cv;
                     end
                     K_FIX8: begin
                        acc_in = acc_sh;
                        bits_in = bits_ff + 6'd1;
                        if (bits_ff + 6'd1 >= 6'd8) begin
                           do_cmp = 1'b1;
                           cv = acc_sh;
                           cw = acc_sh;
                        end
                     end
                     default: begin
                        if (acc_ff == 33'd0) begin
                           if (!bitv) begin
                              lz_in = lz_ff + 6'd1;
                              if (({1'b0, lz_ff} + 7'd1) >= 7'(MAX_CODE_ZEROS)) begin
                                 fail_now = 1'b1;
                                 fail_code = ST_OVERFLOW;
                              end
                           end else begin
                              acc_in = 33'd1;
                              bits_in = '0;
                              if (lz_ff == 6'd0) begin
                                 do_cmp = 1'b1;
                              end
                           end
                        end else begin
                           acc_in = acc_sh;
                           bits_in = bits_ff + 6'd1;
                           if (bits_ff + 6'd1 >= lz_ff) begin
                              do_cmp = 1'b1;
                              code = acc_sh - 33'd1;
                           end
                        end
                        cv = code;
                        if (kind == K_SE) begin
                           cw = code[0] ? ((code + 33'd1) >> 1) : (33'd0 - (code >> 1));
                        end else begin
                           cw = code;
                        end
                     end
                  endcase
               end
               if (bitpos_ff == 3'd0 || step_ff == STEP_DROP) begin
                  bitpos_in = 3'd7;
                  if (head.item.last_byte) begin
                     tail_in = 1'b1;
                  end else begin
                     pop = 1'b1;
                  end
               end else begin
                  bitpos_in = bitpos_ff - 3'd1;
               end
            end
         end
      end

      if (do_cmp) begin
         acc_in = '0;
         bits_in = '0;
         lz_in = '0;
         if (step_ff == F_LOG2FN) begin
            if (cv > LOG2FN_LIMIT) begin
               fail_now = 1'b1;
               fail_code = ST_OVERFLOW;
            end else begin
               emit = 1'b1;
               out_id_in = F_LOG2FN;
               out_idx_in = '0;
               out_val_in = cv + 33'd4;
               out_st_in = ST_OK;
               out_done_in = 1'b0;
               step_in = F_POC_TYPE;
            end
         end else begin
            emit = 1'b1;
            out_id_in = step_ff;
            out_idx_in = (step_ff == F_OFF_REF) ? lcount_ff : 8'd0;
            out_val_in = cw;
            out_st_in = ST_OK;
            out_done_in = 1'b0;
            case (step_ff)
               F_PROFILE: begin
                  prof_in = cv[7:0];
                  step_in = step_ff + 6'd1;
               end
               F_SPS_ID: begin
                  if (is_high(prof_ff)) begin
                     step_in = F_CHROMA;
                  end else begin
                     chroma_in = 2'd1;
                     step_in = F_CAT;
                  end
               end
               F_CHROMA: begin
                  if (cv > 33'd3) begin
                     failp_in = 1'b1;
                     err_in = ST_UNSUPPORTED;
                  end else begin
                     chroma_in = cv[1:0];
                     step_in = (cv == 33'd3) ? F_SEP_PLANE : F_BITDEPTH_L;
                  end
               end
               F_SEP_PLANE: begin
                  sep_in = cv[0];
                  step_in = F_BITDEPTH_L;
               end
               F_SCALING: begin
                  if (cv != 33'd0) begin
                     failp_in = 1'b1;
                     err_in = ST_UNSUPPORTED;
                  end else begin
                     step_in = F_CAT;
                  end
               end
               F_POC_TYPE: begin
                  if (cv == 33'd0) step_in = F_POC_LSB;
                  else if (cv == 33'd1) step_in = F_DELTA_ZERO;
                  else step_in = F_NUM_REF;
               end
               F_POC_LSB: begin
                  step_in = F_NUM_REF;
               end
               F_NUM_CYCLE: begin
                  if (cv > 33'(MAX_CYCLE_OFFSETS)) begin
                     failp_in = 1'b1;
                     err_in = ST_UNSUPPORTED;
                  end else begin
                     llimit_in = cv[7:0];
                     lcount_in = '0;
                     step_in = (cv != 33'd0) ? F_OFF_REF : F_NUM_REF;
                  end
               end
               F_OFF_REF: begin
                  lcount_in = lc_next;
                  step_in = (lc_next >= llimit_ff) ? F_NUM_REF : F_OFF_REF;
               end
               F_FRAME_MBS: begin
                  step_in = cv[0] ? F_DIRECT : F_MBAFF;
               end
               F_CROP: begin
                  step_in = cv[0] ? F_CROP_LEFT : F_VUI;
               end
               F_VUI: begin
                  step_in = cv[0] ? F_ASPECT : STEP_STOP;
               end
               F_BS_RESTR: begin
                  step_in = cv[0] ? F_MV_OVER : STEP_STOP;
               end
               F_MAX_DEC: begin
                  step_in = STEP_STOP;
               end
               default: begin
                  if (step_ff >= F_ASPECT && step_ff <= F_VCL_HRD && cv != 33'd0) begin
                     failp_in = 1'b1;
                     err_in = ST_UNSUPPORTED;
                  end else begin
                     step_in = step_ff + 6'd1;
                  end
               end
            endcase
         end
      end

      if (fail_now) begin
         emit = 1'b1;
         out_id_in = END_ID;
         out_idx_in = '0;
         out_val_in = '0;
         out_st_in = fail_code;
         out_done_in = 1'b1;
         step_in = STEP_DROP;
      end

      if (adv && emit) begin
         out_valid_in = 1'b1;
      end

      if (adv && tail_ff && !failp_ff && step_ff != F_CAT && head.valid &&
          head.item.last_byte) begin
         step_in = F_PROFILE;
         bits_in = '0;
         lz_in = '0;
         acc_in = '0;
         prof_in = '0;
         chroma_in = 2'd1;
         sep_in = 1'b0;
         lcount_in = '0;
         llimit_in = '0;
         err_in = ST_OK;
         failp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= F_PROFILE;
         bits_ff <= '0;
         lz_ff <= '0;
         acc_ff <= '0;
         prof_ff <= '0;
         chroma_ff <= 2'd1;
         sep_ff <= 1'b0;
         lcount_ff <= '0;
         llimit_ff <= '0;
         err_ff <= ST_OK;
         failp_ff <= 1'b0;
         bitpos_ff <= 3'd7;
         tail_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         bits_ff <= bits_in;
         lz_ff <= lz_in;
         acc_ff <= acc_in;
         prof_ff <= prof_in;
         chroma_ff <= chroma_in;
         sep_ff <= sep_in;
         lcount_ff <= lcount_in;
         llimit_ff <= llimit_in;
         err_ff <= err_in;
         failp_ff <= failp_in;
         bitpos_ff <= bitpos_in;
         tail_ff <= tail_in;
         out_valid_ff <= out_valid_in;
      end
      out_id_ff <= out_id_in;
      out_idx_ff <= out_idx_in;
      out_val_ff <= out_val_in;
      out_st_ff <= out_st_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_field_id = out_id_ff;
   assign rsp_element_index = out_idx_ff;
   assign rsp_field_value = out_val_ff;
   assign rsp_parse_status = out_st_ff;
   assign rsp_set_done = out_done_ff;

endmodule

/* rtl/core/h264_sps_bit_parser.sv */
// Top level of the H.264 sequence parameter set parser.
// Usage: feed the RBSP bytes of one parameter set on the req_ channel, most
// significant bit first, with req_last_byte high on the final byte. Each
// syntax element comes back on the rsp_ channel as one record of field id,
// element index and value; a record with rsp_set_done high and field id 48
// closes the set and carries the parse status.
// The back end walks one bit per cycle while bytes are queued and the receiver
// takes its records, and pauses the bit walk for each derived ChromaArrayType
// record, for an end record that follows an element record, and after the
// final byte. A record leaves from the output register in the cycle after the
// bit that completes it; an accepted byte waits in the byte queue until read.
// A two-entry byte queue lets the input side keep accepting while the walker
// is busy. When the receiver stalls, the walker holds with the record in its
// output register, and the queue fills and then drops req_ready.
// Reset clears the queue, the output register and all parse state; the
// parser then waits for the profile byte of a new set.
module h264_sps_bit_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [7:0]  req_rbsp_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [5:0]  rsp_field_id,
   output logic        [7:0]  rsp_element_index,
   output logic signed [32:0] rsp_field_value,
   output logic        [2:0]  rsp_parse_status,
   output logic               rsp_set_done
);
   import sps_pkg::*;

`include "assert_macros.svh"

   item_type req_item;
   head_type head;
   logic     pop;

   assign req_item.rbsp_byte = req_rbsp_byte;
   assign req_item.last_byte = req_last_byte;

   sps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   sps_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_field_id      (rsp_field_id),
      .rsp_element_index (rsp_element_index),
      .rsp_field_value   (rsp_field_value),
      .rsp_parse_status  (rsp_parse_status),
      .rsp_set_done      (rsp_set_done)
   );

   `SPS_ASSERT(a_done_is_end, clock, reset, rsp_valid && rsp_set_done |-> rsp_field_id == END_ID, "end record has wrong id")
   `SPS_ASSERT(a_status_ok, clock, reset, rsp_valid && !rsp_set_done |-> rsp_parse_status == ST_OK, "element record has status")
   `SPS_ASSERT_NEVER(a_index_use, clock, reset, rsp_valid && rsp_element_index != 8'd0 && rsp_field_id != F_OFF_REF, "index on a non-loop record")

endmodule
